// ===== rtl/core/pfd_pkg.sv =====
package pfd_pkg;

    // fixed-point format default
    localparam int FRAC_BITS_DEF = 16;

    // field widths
    localparam int MEAS_W   = 26;
    localparam int DUTY_W   = 23;
    localparam int TIME_W   = 32;
    localparam int TERM_W   = 32;
    localparam int GAIN_W   = 24;
    localparam int WEIGHT_W = 18;
    localparam int POLE_W   = 17;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SETPOINT_WGT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_GAIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_POLE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FF_DISABLE    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE_TIME   = 3'd6;

    // register reset values
    localparam logic [GAIN_W-1:0]   PROP_GAIN_RST     = 24'd65536;
    localparam logic [WEIGHT_W-1:0] SETPOINT_WGT_RST  = 18'd65536;
    localparam logic [GAIN_W-1:0]   INTEGRAL_GAIN_RST = 24'd0;
    localparam logic [POLE_W-1:0]   DERIV_POLE_RST    = 17'd0;
    localparam logic [GAIN_W-1:0]   DERIV_GAIN_RST    = 24'd0;
    localparam logic                FF_DISABLE_RST    = 1'b0;
    localparam logic [TIME_W-1:0]   SETTLE_TIME_RST   = 32'd20000;

    // shared multiplier: unsigned A times signed B
    localparam int MAC_A_W = 24;
    localparam int MAC_B_W = 34;
    localparam int PROD_W  = MAC_A_W + 1 + MAC_B_W;
    // low slice width when a wide operand is fed in two passes
    localparam int SPLIT_W = 24;

    // feedforward: duty * 2.55, rounded half up, via reciprocal of 100
    localparam int FF_W        = 25;
    localparam int FF_SCALE_SH = 8;
    localparam int FFX_W       = DUTY_W + FF_SCALE_SH;
    localparam logic [FFX_W-1:0]   FF_ROUND    = 31'd50;
    localparam logic [FFX_W-1:0]   FF_DIV      = 31'd100;
    localparam logic [MAC_A_W-1:0] FF_RECIP    = 24'd10737418;
    localparam int                 FF_RECIP_SH = 30;

    // error thresholds, in lux and half lux
    localparam int NEAR_LUX      = 5;
    localparam int DEAD_HALF_LUX = 7;

    typedef struct packed {
        logic              mode;
        logic [MEAS_W-1:0] measured;
        logic [MEAS_W-1:0] new_setpoint;
        logic [DUTY_W-1:0] ff_duty;
        logic [TIME_W-1:0] time_us;
    } t_in_item;

    typedef struct packed {
        logic signed [TERM_W-1:0] drive;
        logic                     feedback_active;
    } t_out_item;

    typedef struct packed {
        logic [GAIN_W-1:0]   prop_gain;
        logic [WEIGHT_W-1:0] setpoint_weight;
        logic [GAIN_W-1:0]   integral_gain;
        logic [POLE_W-1:0]   deriv_pole;
        logic [GAIN_W-1:0]   deriv_gain;
        logic                ff_disable;
        logic [TIME_W-1:0]   settle_time_us;
    } t_cfg;

    typedef struct packed {
        logic issue;
        logic accum;
    } t_mac_ctl;

endpackage

// ===== rtl/core/pfd_cfg.sv =====
module pfd_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [pfd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [pfd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output pfd_pkg::t_cfg                  o_cfg
);
    import pfd_pkg::*;

    t_cfg r_cfg;

    // register file, unknown indices dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prop_gain       <= PROP_GAIN_RST;
            r_cfg.setpoint_weight <= SETPOINT_WGT_RST;
            r_cfg.integral_gain   <= INTEGRAL_GAIN_RST;
            r_cfg.deriv_pole      <= DERIV_POLE_RST;
            r_cfg.deriv_gain      <= DERIV_GAIN_RST;
            r_cfg.ff_disable      <= FF_DISABLE_RST;
            r_cfg.settle_time_us  <= SETTLE_TIME_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_PROP_GAIN:     r_cfg.prop_gain       <= i_cfg_data[GAIN_W-1:0];
                REG_SETPOINT_WGT:  r_cfg.setpoint_weight <= i_cfg_data[WEIGHT_W-1:0];
                REG_INTEGRAL_GAIN: r_cfg.integral_gain   <= i_cfg_data[GAIN_W-1:0];
                REG_DERIV_POLE:    r_cfg.deriv_pole      <= i_cfg_data[POLE_W-1:0];
                REG_DERIV_GAIN:    r_cfg.deriv_gain      <= i_cfg_data[GAIN_W-1:0];
                REG_FF_DISABLE:    r_cfg.ff_disable      <= i_cfg_data[0];
                REG_SETTLE_TIME:   r_cfg.settle_time_us  <= i_cfg_data[TIME_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/core/pfd_mac.sv =====
module pfd_mac (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  pfd_pkg::t_mac_ctl                  i_ctl,
    input  logic [pfd_pkg::MAC_A_W-1:0]        i_a,
    input  logic signed [pfd_pkg::MAC_B_W-1:0] i_b,
    output logic signed [pfd_pkg::PROD_W-1:0]  o_acc
);
    import pfd_pkg::*;

    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] n_prod;
    logic signed [PROD_W-1:0] r_acc;
    logic signed [PROD_W-1:0] n_acc;
    logic                     r_step;
    logic                     r_accum;

    // stage 1: product register
    always_comb begin
        n_prod = $signed({1'b0, i_a}) * i_b;
    end

    // stage 2: load, or shift the high pass up and add the low pass
    always_comb begin
        if (r_accum) begin
            n_acc = (r_acc <<< SPLIT_W) + r_prod;
        end else begin
            n_acc = r_prod;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= 1'b0;
            r_accum <= 1'b0;
        end else begin
            r_step  <= i_ctl.issue;
            r_accum <= i_ctl.issue & i_ctl.accum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.issue) begin
            r_prod <= n_prod;
        end
        if (r_step) begin
            r_acc <= n_acc;
        end
    end

    assign o_acc = r_acc;

endmodule

// ===== rtl/core/pid_feedforward_deadzone_controller.sv =====
// Sequencer path per item: a sample without feedback goes through DECIDE and
// OUT, a sample with feedback through DECIDE, FB1 to FB8 and OUT, a setpoint
// item through DECIDE, SP1 to SP4 and OUT. One item at a time, taken in IDLE;
// products use the single shared multiplier (two-stage multiply-accumulate).
// Synchronous active-low reset clears the sequencer, loop state and registers;
// afterwards the block is ready at once.
module pid_feedforward_deadzone_controller #(
    parameter int FRAC_BITS = pfd_pkg::FRAC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  pfd_pkg::t_in_item              i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output pfd_pkg::t_out_item             o_out_data,
    input  logic                           i_cfg_we,
    input  logic [pfd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [pfd_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import pfd_pkg::*;

    // width kept for (b*target - measured); Kp*D mod 2^(F+32) only needs this
    localparam int D_W   = FRAC_BITS + TERM_W;
    localparam int HI_W  = D_W - SPLIT_W;
    localparam int MAG_W = MEAS_W + 1;
    localparam logic [MAG_W-1:0] NEAR_LIM = MAG_W'(NEAR_LUX << FRAC_BITS);
    localparam logic [MAG_W-1:0] DEAD_LIM = MAG_W'(DEAD_HALF_LUX << (FRAC_BITS - 1));

    typedef enum logic [14:0] {
        ST_IDLE   = 15'd1,
        ST_DECIDE = 15'd2,
        ST_FB1    = 15'd4,
        ST_FB2    = 15'd8,
        ST_FB3    = 15'd16,
        ST_FB4    = 15'd32,
        ST_FB5    = 15'd64,
        ST_FB6    = 15'd128,
        ST_FB7    = 15'd256,
        ST_FB8    = 15'd512,
        ST_SP1    = 15'd1024,
        ST_SP2    = 15'd2048,
        ST_SP3    = 15'd4096,
        ST_SP4    = 15'd8192,
        ST_OUT    = 15'd16384
    } t_state;

    t_state r_state;
    t_state n_state;
    t_cfg   w_cfg;

    // loop state
    logic        [MEAS_W-1:0] r_target;
    logic        [FF_W-1:0]   r_ff_level;
    logic        [TERM_W-1:0] r_prop;
    logic        [TERM_W-1:0] r_integ;
    logic        [TERM_W-1:0] r_deriv;
    logic signed [MEAS_W:0]   r_last_err;
    logic        [MEAS_W-1:0] r_last_meas;
    logic                     r_fb_on;
    logic                     r_needs_init;
    logic        [TIME_W-1:0] r_change_time;

    // per-item working registers
    t_in_item                 r_item;
    logic signed [MEAS_W:0]   r_err;
    logic signed [MEAS_W+1:0] r_esum;
    logic signed [MEAS_W:0]   r_mdiff;
    logic        [D_W-1:0]    r_diff;
    logic        [TERM_W-1:0] r_dpart;
    logic        [FFX_W-1:0]  r_ffx;
    logic        [FF_W-1:0]   r_q;
    logic        [FFX_W-1:0]  r_q100;
    logic                     r_use_terms;
    logic                     r_use_ff;
    logic                     r_active;
    logic                     r_out_valid;
    t_out_item                r_out;

    logic signed [MEAS_W:0]    w_err;
    logic        [MAG_W-1:0]   w_mag;
    logic                      w_near;
    logic                      w_dead;
    logic        [TIME_W-1:0]  w_elapsed;
    logic                      w_settle;
    logic                      w_fb_on;
    logic                      w_use_fb;
    logic        [FFX_W-1:0]   w_ffx;
    logic                      w_in_take;
    logic                      w_out_load;
    logic        [TERM_W-1:0]  w_drive;
    logic        [FF_W-1:0]    w_q0;
    logic                      w_round_up;
    t_mac_ctl                  w_mac_ctl;
    logic        [MAC_A_W-1:0] w_mac_a;
    logic signed [MAC_B_W-1:0] w_mac_b;
    logic signed [PROD_W-1:0]  w_acc;
    logic signed [PROD_W-1:0]  w_acc_sh;
    logic signed [PROD_W-1:0]  w_acc_sh1;

    pfd_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    pfd_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_mac_ctl),
        .i_a     (w_mac_a),
        .i_b     (w_mac_b),
        .o_acc   (w_acc)
    );

    // handshakes
    assign w_in_take  = i_in_valid && (r_state == ST_IDLE);
    assign w_out_load = (r_state == ST_OUT) && (!r_out_valid || !i_out_stall);
    assign o_in_stall = (r_state != ST_IDLE);

    // error, thresholds and settle test
    assign w_err     = $signed({1'b0, r_target}) - $signed({1'b0, r_item.measured});
    assign w_mag     = w_err[MEAS_W] ? MAG_W'(-w_err) : MAG_W'(w_err);
    assign w_near    = (w_mag <= NEAR_LIM);
    assign w_dead    = (w_mag < DEAD_LIM);
    assign w_elapsed = r_item.time_us - r_change_time;
    assign w_settle  = (w_elapsed > w_cfg.settle_time_us);
    assign w_fb_on   = r_fb_on | w_settle;
    assign w_use_fb  = (w_near | w_cfg.ff_disable | w_fb_on) & (~w_dead | r_needs_init);

    // duty * 255 + 50, ahead of the divide by 100
    assign w_ffx = {r_item.ff_duty, {FF_SCALE_SH{1'b0}}}
                 - {{FF_SCALE_SH{1'b0}}, r_item.ff_duty} + FF_ROUND;

    // product views: floor shifts of the accumulator
    assign w_acc_sh   = w_acc >>> FRAC_BITS;
    assign w_acc_sh1  = w_acc >>> (FRAC_BITS + 1);
    assign w_q0       = w_acc[FF_RECIP_SH+FF_W-1:FF_RECIP_SH];
    assign w_round_up = ((r_ffx - r_q100) >= FF_DIV);

    // result sum
    assign w_drive = (r_use_terms ? (r_prop + r_integ + r_deriv) : '0)
                   + (r_use_ff ? {{(TERM_W-FF_W){1'b0}}, r_ff_level} : '0);

    // multiplier operand selection per step
    always_comb begin
        w_mac_ctl = '0;
        w_mac_a   = '0;
        w_mac_b   = '0;
        unique case (r_state)
            ST_FB1: begin
                w_mac_ctl.issue = 1'b1;
                w_mac_a = {{(MAC_A_W-WEIGHT_W){1'b0}}, w_cfg.setpoint_weight};
                w_mac_b = {{(MAC_B_W-MEAS_W){1'b0}}, r_target};
            end
            ST_FB2: begin
                w_mac_ctl.issue = 1'b1;
                w_mac_a = w_cfg.integral_gain;
                w_mac_b = {{(MAC_B_W-MEAS_W-2){r_esum[MEAS_W+1]}}, r_esum};
            end
            ST_FB3: begin
                w_mac_ctl.issue = 1'b1;
                w_mac_a = {{(MAC_A_W-POLE_W){1'b0}}, w_cfg.deriv_pole};
                w_mac_b = {{(MAC_B_W-TERM_W){r_deriv[TERM_W-1]}}, r_deriv};
            end
            ST_FB4: begin
                w_mac_ctl.issue = 1'b1;
                w_mac_a = w_cfg.deriv_gain;
                w_mac_b = {{(MAC_B_W-MEAS_W-1){r_mdiff[MEAS_W]}}, r_mdiff};
            end
            ST_FB5: begin
                w_mac_ctl.issue = 1'b1;
                w_mac_a = w_cfg.prop_gain;
                w_mac_b = {{(MAC_B_W-HI_W){r_diff[D_W-1]}}, r_diff[D_W-1:SPLIT_W]};
            end
            ST_FB6: begin
                w_mac_ctl.issue = 1'b1;
                w_mac_ctl.accum = 1'b1;
                w_mac_a = w_cfg.prop_gain;
                w_mac_b = {{(MAC_B_W-SPLIT_W){1'b0}}, r_diff[SPLIT_W-1:0]};
            end
            ST_SP1: begin
                w_mac_ctl.issue = 1'b1;
                w_mac_a = FF_RECIP;
                w_mac_b = {{(MAC_B_W-FFX_W){1'b0}}, r_ffx};
            end
            default: ;
        endcase
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (w_in_take) n_state = ST_DECIDE;
            ST_DECIDE: begin
                priority if (r_item.mode) n_state = ST_SP1;
                else if (w_use_fb)        n_state = ST_FB1;
                else                      n_state = ST_OUT;
            end
            ST_FB1:    n_state = ST_FB2;
            ST_FB2:    n_state = ST_FB3;
            ST_FB3:    n_state = ST_FB4;
            ST_FB4:    n_state = ST_FB5;
            ST_FB5:    n_state = ST_FB6;
            ST_FB6:    n_state = ST_FB7;
            ST_FB7:    n_state = ST_FB8;
            ST_FB8:    n_state = ST_OUT;
            ST_SP1:    n_state = ST_SP2;
            ST_SP2:    n_state = ST_SP3;
            ST_SP3:    n_state = ST_SP4;
            ST_SP4:    n_state = ST_OUT;
            ST_OUT:    if (w_out_load) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // control and loop state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_out_valid   <= 1'b0;
            r_target      <= '0;
            r_ff_level    <= '0;
            r_prop        <= '0;
            r_integ       <= '0;
            r_deriv       <= '0;
            r_last_err    <= '0;
            r_last_meas   <= '0;
            r_fb_on       <= 1'b0;
            r_needs_init  <= 1'b1;
            r_change_time <= '0;
        end else begin
            r_state <= n_state;

            // output register: load, or empty on transfer
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_DECIDE: begin
                    if (r_item.mode) begin
                        if (r_item.new_setpoint != '0) begin
                            r_target <= r_item.new_setpoint;
                        end
                        r_fb_on       <= 1'b0;
                        r_needs_init  <= 1'b1;
                        r_change_time <= r_item.time_us;
                    end else begin
                        r_fb_on <= w_fb_on | (w_use_fb & r_needs_init);
                        // first feedback update: clear the integral term and the last measurement
                        if (w_use_fb && r_needs_init) begin
                            r_last_meas  <= '0;
                            r_integ      <= '0;
                            r_needs_init <= 1'b0;
                        end
                    end
                end
                ST_FB4: r_integ <= r_integ + w_acc_sh1[TERM_W-1:0];
                ST_FB6: r_deriv <= r_dpart - w_acc_sh[TERM_W-1:0];
                ST_FB8: begin
                    r_prop      <= w_acc_sh[TERM_W-1:0];
                    r_last_err  <= r_err;
                    r_last_meas <= r_item.measured;
                end
                ST_SP4: r_ff_level <= r_q + FF_W'(w_round_up);
                default: ;
            endcase
        end
    end

    // working registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_item <= i_in_data;
        end
        unique case (r_state)
            ST_DECIDE: begin
                r_err <= w_err;
                r_ffx <= w_ffx;
                if (r_item.mode) begin
                    r_use_terms <= 1'b0;
                    r_use_ff    <= 1'b1;
                    r_active    <= 1'b0;
                end else if (w_use_fb) begin
                    r_use_terms <= 1'b1;
                    r_use_ff    <= ~w_cfg.ff_disable;
                    r_active    <= 1'b1;
                end else begin
                    // held terms only inside the dead zone
                    r_use_terms <= w_dead;
                    r_use_ff    <= 1'b1;
                    r_active    <= 1'b0;
                end
            end
            ST_FB1: begin
                r_esum  <= {r_err[MEAS_W], r_err} + {r_last_err[MEAS_W], r_last_err};
                r_mdiff <= $signed({1'b0, r_item.measured}) - $signed({1'b0, r_last_meas});
            end
            ST_FB3: begin
                r_diff <= w_acc_sh[D_W-1:0] - {{(D_W-MEAS_W){1'b0}}, r_item.measured};
            end
            ST_FB5: r_dpart <= w_acc_sh[TERM_W-1:0];
            ST_SP3: begin
                // quotient estimate is exact or one short
                r_q    <= w_q0;
                r_q100 <= {{(FFX_W-FF_W){1'b0}}, w_q0} * FF_DIV;
            end
            default: ;
        endcase
        if (w_out_load) begin
            r_out.drive           <= w_drive;
            r_out.feedback_active <= r_active;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== rtl/core/pfd_checker.sv =====
module pfd_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input pfd_pkg::t_out_item o_out_data
);
    import pfd_pkg::*;

    // an accepted item keeps the input side busy next cycle
    a_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after transfer");

    // a fresh result coincides with the block being ready again
    a_result_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !o_in_stall)
        else $error("result raised while still busy");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed");

    // reset leaves the block empty and ready
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !o_in_stall))
        else $error("not idle after reset");

endmodule

bind pid_feedforward_deadzone_controller pfd_checker u_pfd_checker (.*);

// ===== tb/pfd_drive_checker.sv =====
// Watches both channels of the illuminance regulator, keeps its own copy of
// the loop state and registers, predicts the drive for every input transfer
// and compares it with the output transfers in order.
module pfd_drive_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  pfd_pkg::t_in_item              i_in_data,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  pfd_pkg::t_out_item             i_out_data,
    input  logic                           i_cfg_we,
    input  logic [pfd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [pfd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                             o_mismatches,
    output int                             o_pending,
    output int                             o_checked
);
    import pfd_pkg::*;

    localparam int FB = FRAC_BITS_DEF;

    // register copy
    t_cfg regs;

    // loop state copy
    logic [31:0] tgt_lux, ff_out, p_term, int_term, d_term;
    logic [31:0] prev_err, prev_meas, sp_time;
    bit          fb_on, init_due;

    t_out_item pending_drives[$];
    t_out_item predicted, want, got;
    int        fails;
    int        checked;

    // Qn.FB product back to Qn, floor
    function automatic longint fx_down(input longint v);
        return v >>> FB;
    endfunction

    // one input transfer: update state, return the drive it should produce
    task automatic predict_drive(input t_in_item it, output t_out_item res);
        longint      meas, err, mag, bt, p, inc, acc, d, ff;
        logic [31:0] elapsed;
        logic [31:0] drv;
        bit          near_tgt, dead_zone, active;
        meas   = longint'(it.measured);
        drv    = '0;
        active = 1'b0;
        if (it.mode) begin
            // setpoint: zero keeps the old target, everything else restarts
            if (it.new_setpoint != '0) tgt_lux = 32'(it.new_setpoint);
            ff_out   = 32'((64'(it.ff_duty) * 64'd255 + 64'd50) / 64'd100);
            fb_on    = 1'b0;
            init_due = 1'b1;
            sp_time  = it.time_us;
            drv      = ff_out;
        end else begin
            err       = longint'(tgt_lux) - meas;
            mag       = (err < 0) ? -err : err;
            near_tgt  = mag <= (longint'(NEAR_LUX) << FB);
            dead_zone = mag < (longint'(DEAD_HALF_LUX) << (FB - 1));
            elapsed   = it.time_us - sp_time;
            if (elapsed > regs.settle_time_us) fb_on = 1'b1;

            if ((near_tgt || regs.ff_disable || fb_on) && (!dead_zone || init_due)) begin
                if (init_due) begin
                    prev_meas = '0;
                    int_term  = '0;
                    init_due  = 1'b0;
                    fb_on     = 1'b1;
                end
                bt  = fx_down(longint'(regs.setpoint_weight) * longint'(tgt_lux));
                p   = fx_down(longint'(regs.prop_gain) * (bt - meas));
                inc = fx_down(longint'(regs.integral_gain) *
                              (err + longint'($signed(prev_err)))) >>> 1;
                acc = longint'($signed(int_term)) + inc;
                d   = fx_down(longint'(regs.deriv_pole) * longint'($signed(d_term)))
                    - fx_down(longint'(regs.deriv_gain) *
                              (meas - longint'($signed(prev_meas))));
                ff  = regs.ff_disable ? 64'sd0 : longint'(ff_out);

                p_term    = p[31:0];
                int_term  = acc[31:0];
                d_term    = d[31:0];
                prev_err  = err[31:0];
                prev_meas = meas[31:0];
                drv       = p_term + int_term + d_term + ff[31:0];
                active    = 1'b1;
            end else if (dead_zone) begin
                // held terms, feedforward added whatever ff_disable says
                drv = ff_out + p_term + int_term + d_term;
            end else begin
                drv = ff_out;
            end
        end
        res.drive           = drv;
        res.feedback_active = active;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            regs.prop_gain       = PROP_GAIN_RST;
            regs.setpoint_weight = SETPOINT_WGT_RST;
            regs.integral_gain   = INTEGRAL_GAIN_RST;
            regs.deriv_pole      = DERIV_POLE_RST;
            regs.deriv_gain      = DERIV_GAIN_RST;
            regs.ff_disable      = FF_DISABLE_RST;
            regs.settle_time_us  = SETTLE_TIME_RST;
            tgt_lux   = '0;
            ff_out    = '0;
            p_term    = '0;
            int_term  = '0;
            d_term    = '0;
            prev_err  = '0;
            prev_meas = '0;
            sp_time   = '0;
            fb_on     = 1'b0;
            init_due  = 1'b1;
            pending_drives.delete();
            fails   = 0;
            checked = 0;
        end else begin
            // register writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_PROP_GAIN:     regs.prop_gain       = i_cfg_data[GAIN_W-1:0];
                    REG_SETPOINT_WGT:  regs.setpoint_weight = i_cfg_data[WEIGHT_W-1:0];
                    REG_INTEGRAL_GAIN: regs.integral_gain   = i_cfg_data[GAIN_W-1:0];
                    REG_DERIV_POLE:    regs.deriv_pole      = i_cfg_data[POLE_W-1:0];
                    REG_DERIV_GAIN:    regs.deriv_gain      = i_cfg_data[GAIN_W-1:0];
                    REG_FF_DISABLE:    regs.ff_disable      = i_cfg_data[0];
                    REG_SETTLE_TIME:   regs.settle_time_us  = i_cfg_data[TIME_W-1:0];
                    default: ;
                endcase
            end

            // result transfer against the oldest prediction
            if (i_out_valid && !i_out_stall) begin
                got = i_out_data;
                if (pending_drives.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("%0t chk: result with nothing expected, drive %h fb %0b",
                                 $realtime, got.drive, got.feedback_active);
                end else begin
                    want = pending_drives.pop_front();
                    checked++;
                    if (got.drive !== want.drive ||
                        got.feedback_active !== want.feedback_active) begin
                        fails++;
                        if (fails <= 10)
                            $display({"%0t chk: drive exp %h (%0d) got %h (%0d),",
                                      " fb exp %0b got %0b"},
                                     $realtime, want.drive, want.drive, got.drive, got.drive,
                                     want.feedback_active, got.feedback_active);
                    end
                end
            end

            // input transfer
            if (i_in_valid && !i_in_stall) begin
                predict_drive(i_in_data, predicted);
                pending_drives.push_back(predicted);
            end
        end
        o_mismatches <= fails;
        o_pending    <= pending_drives.size();
        o_checked    <= checked;
    end

endmodule

// ===== tb/tb.sv =====
module tb;
    import pfd_pkg::*;

    // index with no register behind it
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
    localparam int LUX = 1 << FRAC_BITS_DEF;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    t_in_item              in_data   = '0;
    logic                  out_stall = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_stall;
    logic                  out_valid;
    t_out_item             out_data;

    int mismatches;
    int pending;
    int checked;

    int          send_idle_pct = 14;
    int          recv_idle_pct = 75;
    int          hold_req      = 0;
    int          items_sent    = 0;
    logic [31:0] now_us        = '0;
    logic [31:0] tgt_q         = '0;

    pid_feedforward_deadzone_controller u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    pfd_drive_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always #2 clk = ~clk;

    // hard stop
    initial begin
        #2_000_000;
        $display("tb: done, errors");
        $finish;
    end

    // receiver: random stall, or a long hold-off when one is requested
    initial begin : rx_side
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge clk);
            if (hold_req > 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0) begin
                out_stall <= 1'b1;
                hold_left--;
            end else begin
                out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    // sample item, unused fields random
    function automatic t_in_item mk_sample(input logic [31:0] meas, input logic [31:0] t);
        t_in_item it;
        it.mode         = 1'b0;
        it.measured     = meas[MEAS_W-1:0];
        it.new_setpoint = MEAS_W'($urandom());
        it.ff_duty      = DUTY_W'($urandom());
        it.time_us      = t;
        return it;
    endfunction

    // setpoint item, measured random
    function automatic t_in_item mk_setpoint(input logic [MEAS_W-1:0] sp,
                                            input logic [DUTY_W-1:0] duty,
                                            input logic [31:0] t);
        t_in_item it;
        it.mode         = 1'b1;
        it.measured     = MEAS_W'($urandom());
        it.new_setpoint = sp;
        it.ff_duty      = duty;
        it.time_us      = t;
        return it;
    endfunction

    // one transfer, then maybe a gap; valid stays up when there is none
    task automatic send_item(input t_in_item it);
        in_data  <= it;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        items_sent++;
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    // stop sending until every result is back, then let the block settle
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        // margin for the longest item, a sample with feedback
        repeat (12) @(posedge clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
    endtask

    task automatic load_regs(input t_cfg c);
        cfg_we <= 1'b1;
        put_reg(REG_SPARE, $urandom());
        put_reg(REG_PROP_GAIN, 32'(c.prop_gain));
        put_reg(REG_SETPOINT_WGT, 32'(c.setpoint_weight));
        put_reg(REG_INTEGRAL_GAIN, 32'(c.integral_gain));
        put_reg(REG_DERIV_POLE, 32'(c.deriv_pole));
        put_reg(REG_DERIV_GAIN, 32'(c.deriv_gain));
        put_reg(REG_FF_DISABLE, 32'(c.ff_disable));
        put_reg(REG_SETTLE_TIME, c.settle_time_us);
        cfg_we <= 1'b0;
    endtask

    // settings with random gains; wide selects the full register widths
    function automatic t_cfg random_regs(input bit wide);
        t_cfg c;
        c.prop_gain       = wide ? GAIN_W'($urandom()) : GAIN_W'($urandom_range(0, 8 * LUX));
        c.setpoint_weight = wide ? WEIGHT_W'($urandom()) : WEIGHT_W'($urandom_range(0, 2 * LUX));
        c.integral_gain   = wide ? GAIN_W'($urandom()) : GAIN_W'($urandom_range(0, LUX));
        c.deriv_pole      = wide ? POLE_W'($urandom()) : POLE_W'($urandom_range(0, LUX));
        c.deriv_gain      = wide ? GAIN_W'($urandom()) : GAIN_W'($urandom_range(0, 2 * LUX));
        c.ff_disable      = 1'($urandom_range(1));
        c.settle_time_us  = $urandom_range(0, 50000);
        return c;
    endfunction

    // Random traffic: mostly a setpoint followed by a run of samples around
    // the target, some runs with no setpoint, some bursts of raw noise.
    task automatic run_traffic(input int n_items);
        int          start, n_samp, kind, span, off;
        logic [31:0] meas;
        logic [25:0] sp;
        t_in_item    junk;
        start = items_sent;
        while (items_sent - start < n_items) begin
            kind = $urandom_range(99);
            if (kind < 15) begin
                repeat ($urandom_range(1, 5)) begin
                    junk.mode         = 1'($urandom_range(1));
                    junk.measured     = MEAS_W'($urandom());
                    junk.new_setpoint = MEAS_W'($urandom());
                    junk.ff_duty      = DUTY_W'($urandom());
                    junk.time_us      = $urandom();
                    send_item(junk);
                end
            end else begin
                if (kind >= 25) begin
                    kind = $urandom_range(99);
                    if (kind < 80)      sp = MEAS_W'($urandom_range(LUX, 1000 * LUX));
                    else if (kind < 90) sp = '0;
                    else                sp = MEAS_W'($urandom());
                    if (sp != '0) tgt_q = 32'(sp);
                    send_item(mk_setpoint(sp, ($urandom_range(9) == 0) ? DUTY_W'($urandom())
                                              : DUTY_W'($urandom_range(0, 100 * LUX)), now_us));
                end
                n_samp = $urandom_range(1, 30);
                repeat (n_samp) begin
                    if ($urandom_range(49) == 0) now_us += $urandom();
                    else                         now_us += $urandom_range(200, 3000);
                    kind = $urandom_range(99);
                    if (kind < 40)      span = 7 * LUX / 2;
                    else if (kind < 70) span = 5 * LUX + 1;
                    else if (kind < 90) span = 40 * LUX;
                    else                span = 0;
                    if (span == 0) begin
                        meas = $urandom();
                    end else begin
                        off  = int'($urandom_range(2 * span)) - span;
                        meas = tgt_q + 32'(off);
                    end
                    send_item(mk_sample(meas, now_us));
                end
            end
        end
    endtask

    initial begin : stim
        t_cfg        c;
        logic [31:0] t0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, register reset values
        send_item(mk_sample(32'd0, 32'd0));
        send_item(mk_sample(32'h03FF_FFFF, 32'd100));
        send_item(mk_setpoint('0, '1, 32'd1000));
        send_item(mk_sample(32'd0, 32'd1100));
        send_item(mk_setpoint(MEAS_W'(100 * LUX), DUTY_W'(50 * LUX), 32'd2000));
        send_item(mk_sample(32'(50 * LUX), 32'd2100));
        // edge of the near band, edge of the dead zone on both sides
        send_item(mk_sample(32'(95 * LUX), 32'd2200));
        send_item(mk_sample(32'(100 * LUX + 7 * LUX / 2), 32'd2300));
        send_item(mk_sample(32'(100 * LUX - 7 * LUX / 2 + 1), 32'd2400));
        send_item(mk_sample(32'(105 * LUX + 1), 32'd2500));
        // settle timer across the timestamp wrap
        send_item(mk_setpoint(MEAS_W'(200 * LUX), '0, 32'hFFFF_F000));
        send_item(mk_sample(32'(150 * LUX), 32'hFFFF_F100));
        send_item(mk_sample(32'(150 * LUX), 32'h0000_4000));
        // settle exactly at the limit, then one past it
        t0 = 32'h0001_0000;
        send_item(mk_setpoint('1, DUTY_W'(100 * LUX), t0));
        send_item(mk_sample(32'd0, t0 + 32'd20000));
        send_item(mk_sample(32'd0, t0 + 32'd20001));
        send_item(mk_sample(32'h03FF_FFFF, t0 + 32'd20002));
        send_item(mk_setpoint(MEAS_W'(1), '1, 32'hFFFF_FFFF));
        send_item(mk_sample(32'h03FF_FFFF, 32'hFFFF_FFFF));
        send_item(mk_sample(32'd1, 32'd0));
        drain();
        now_us = $urandom();

        // sender idles lightly, receiver heavily
        c.prop_gain       = GAIN_W'(2 * LUX);
        c.setpoint_weight = WEIGHT_W'(3 * LUX / 4);
        c.integral_gain   = GAIN_W'(LUX / 10);
        c.deriv_pole      = POLE_W'(LUX / 2);
        c.deriv_gain      = GAIN_W'(3 * LUX / 10);
        c.ff_disable      = 1'b0;
        c.settle_time_us  = 32'd20000;
        load_regs(c);
        run_traffic(250);
        drain();
        c.prop_gain       = '1;
        c.setpoint_weight = '1;
        c.integral_gain   = '1;
        c.deriv_pole      = '1;
        c.deriv_gain      = '1;
        c.ff_disable      = 1'b1;
        c.settle_time_us  = '1;
        load_regs(c);
        run_traffic(250);
        drain();

        // the other way round
        send_idle_pct = 75;
        recv_idle_pct = 14;
        c = '0;
        load_regs(c);
        run_traffic(250);
        drain();
        load_regs(random_regs(1'b1));
        run_traffic(250);
        drain();

        // no idling; a long output hold-off fills the block up
        send_idle_pct = 0;
        recv_idle_pct = 0;
        c = random_regs(1'b0);
        c.ff_disable     = 1'b0;
        c.settle_time_us = 32'd3000;
        load_regs(c);
        hold_req = 400;
        run_traffic(250);
        drain();
        load_regs(random_regs(1'b0));
        run_traffic(250);
        drain();

        $display("tb: %0d items sent, %0d results compared over seven register settings",
                 items_sent, checked);
        $display("tb: swapped idling, a long output hold-off, settle wrap, dead zone edges");
        if (mismatches == 0 && pending == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/pfd_pkg.sv
rtl/core/pfd_cfg.sv
rtl/core/pfd_mac.sv
rtl/core/pid_feedforward_deadzone_controller.sv
rtl/core/pfd_checker.sv
tb/pfd_drive_checker.sv
tb/tb.sv
